@@ rtl/sd_host_register_block_assert.svh @@
// Assertion macros for the SD host register block.
`ifndef SD_HOST_REGISTER_BLOCK_ASSERT_SVH
`define SD_HOST_REGISTER_BLOCK_ASSERT_SVH

// Implication checked on every clock outside reset.
`define SDH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdh_pkg.sv @@
`default_nettype none
package sdh_pkg;

  localparam logic [31:0] SR_RESET_VALUE = 32'h0000_C0E5;
  localparam logic [31:0] VERSION_VALUE  = 32'h0000_0300;
  localparam int unsigned BIT_CMDRDY  = 0;
  localparam int unsigned BIT_RXRDY   = 1;
  localparam int unsigned BIT_TXRDY   = 2;
  localparam int unsigned BIT_BLKE    = 3;
  localparam int unsigned BIT_NOTBUSY = 5;
  localparam int unsigned BIT_TRDIR   = 18;
  localparam int unsigned BIT_RTOE    = 20;
  localparam int unsigned BIT_SWRST   = 7;

  // Register word offsets
  localparam logic [8:0] OFS_CR      = 9'd0;
  localparam logic [8:0] OFS_MR      = 9'd1;
  localparam logic [8:0] OFS_DTOR    = 9'd2;
  localparam logic [8:0] OFS_SDCR    = 9'd3;
  localparam logic [8:0] OFS_ARGR    = 9'd4;
  localparam logic [8:0] OFS_CMDR    = 9'd5;
  localparam logic [8:0] OFS_BLKR    = 9'd6;
  localparam logic [8:0] OFS_CSTOR   = 9'd7;
  localparam logic [8:0] OFS_RSPR0   = 9'd8;
  localparam logic [8:0] OFS_RSPR1   = 9'd9;
  localparam logic [8:0] OFS_RSPR2   = 9'd10;
  localparam logic [8:0] OFS_RSPR3   = 9'd11;
  localparam logic [8:0] OFS_RDR     = 9'd12;
  localparam logic [8:0] OFS_TDR     = 9'd13;
  localparam logic [8:0] OFS_SR      = 9'd16;
  localparam logic [8:0] OFS_IER     = 9'd17;
  localparam logic [8:0] OFS_IDR     = 9'd18;
  localparam logic [8:0] OFS_IMR     = 9'd19;
  localparam logic [8:0] OFS_DMA     = 9'd20;
  localparam logic [8:0] OFS_CFG     = 9'd21;
  localparam logic [8:0] OFS_WPMR    = 9'd57;
  localparam logic [8:0] OFS_WPSR    = 9'd58;
  localparam logic [8:0] OFS_VERSION = 9'd63;

  typedef enum logic [4:0] {
    K_NONE  = 5'b00001,
    K_READ  = 5'b00010,
    K_WRITE = 5'b00100,
    K_CMD   = 5'b01000,
    K_DATA  = 5'b10000
  } kind_t;

  typedef struct packed {
    logic        op;
    logic [8:0]  word_offset;
    logic [31:0] write_data;
    logic [4:0]  card_resp_len;
    logic [63:0] card_resp_high;
    logic [63:0] card_resp_low;
    logic [31:0] card_read_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        data_req;
    logic        card_cmd_valid;
    logic [5:0]  card_cmd_index;
    logic [31:0] card_cmd_arg;
    logic        card_read_taken;
    logic        card_write_valid;
    logic [31:0] card_write_word;
  } out_item_t;

  // Classified access handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [8:0]  ofs;   // FIFO window folded onto RDR/TDR
    logic [31:0] wdata;
    logic [4:0]  rlen;  // saturated to 16
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] cword;
  } op_t;

endpackage
`default_nettype wire

@@ rtl/sdh_front.sv @@
`default_nettype none
module sdh_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sdh_pkg::in_item_t in_data,
  output logic                   q_valid,
  input  wire logic              q_stall,
  output sdh_pkg::op_t           q_data
);
  `include "sd_host_register_block_assert.svh"

  // Two-entry queue
  sdh_pkg::op_t mem_r [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  sdh_pkg::op_t cls;
  logic         push, pop;

  always_comb begin
    cls.ofs   = (in_data.word_offset[8:7] != 2'b00) ?
                (in_data.op ? sdh_pkg::OFS_TDR : sdh_pkg::OFS_RDR) : in_data.word_offset;
    cls.wdata = in_data.write_data;
    cls.rlen  = (in_data.card_resp_len > 5'd16) ? 5'd16 : in_data.card_resp_len;
    cls.hi    = in_data.card_resp_high;
    cls.lo    = in_data.card_resp_low;
    cls.cword = in_data.card_read_word;
    // only RDR reads and TDR writes move data; the other direction is unmapped
    if ((!in_data.op && cls.ofs == sdh_pkg::OFS_RDR) ||
        (in_data.op && cls.ofs == sdh_pkg::OFS_TDR)) begin
      cls.kind = sdh_pkg::K_DATA;
    end else if (in_data.op && cls.ofs == sdh_pkg::OFS_CMDR) begin
      cls.kind = sdh_pkg::K_CMD;
    end else if (in_data.op) begin
      cls.kind = sdh_pkg::K_WRITE;
    end else begin
      cls.kind = sdh_pkg::K_READ;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && !q_stall;
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  `SDH_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r != 2'd3, "queue count overflow")
  `SDH_ASSERT_NEXT(a_push_only, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push lost")
  `SDH_ASSERT_IMPL(a_ptr_eq, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r, "pointer mismatch")
endmodule
`default_nettype wire

@@ rtl/sdh_back.sv @@
`default_nettype none
module sdh_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_stall,
  input  wire sdh_pkg::op_t       q_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sdh_pkg::out_item_t      out_data
);
  `include "sd_host_register_block_assert.svh"

  logic [31:0] mode_r, dtor_r, sel_r, arg_r, blk_r, cstor_r, dma_r, cfg_r, wpmr_r;
  logic [31:0] sr_r, imr_r;
  logic [31:0] rsp_r [4];
  logic [1:0]  rptr_r;
  logic [15:0] cblen_r;
  logic [31:0] left_r;
  logic        rdir_r;

  logic [31:0] mode_nxt, dtor_nxt, sel_nxt, arg_nxt, blk_nxt, cstor_nxt, dma_nxt;
  logic [31:0] cfg_nxt, wpmr_nxt, sr_nxt, imr_nxt;
  logic [31:0] rsp_nxt [4];
  logic [1:0]  rptr_nxt;
  logic [15:0] cblen_nxt;
  logic [31:0] left_nxt;
  logic        rdir_nxt;

  sdh_pkg::out_item_t res, out_r, out_nxt;
  logic        ov_r, ov_nxt, go;
  logic [15:0] blen, bcnt;
  logic [31:0] total;
  logic [1:0]  rtype;
  logic        dir_ok;

  assign q_stall   = ov_r && out_stall;
  assign go        = q_valid && !q_stall;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // 16x16 transfer length product
  assign blen  = (blk_r[31:16] == 16'd0) ? mode_r[31:16] : blk_r[31:16];
  assign bcnt  = (blk_r[15:0] == 16'd0) ? 16'd1 : blk_r[15:0];
  assign total = blen * bcnt;
  assign rtype = q_data.wdata[7:6];
  assign dir_ok = (left_r != 32'd0) &&
                  (q_data.ofs == sdh_pkg::OFS_RDR ? rdir_r : !rdir_r);

  always_comb begin
    mode_nxt = mode_r; dtor_nxt = dtor_r; sel_nxt = sel_r; arg_nxt = arg_r;
    blk_nxt = blk_r; cstor_nxt = cstor_r; dma_nxt = dma_r; cfg_nxt = cfg_r;
    wpmr_nxt = wpmr_r; sr_nxt = sr_r; imr_nxt = imr_r;
    for (int i = 0; i < 4; i++) rsp_nxt[i] = rsp_r[i];
    rptr_nxt = rptr_r; cblen_nxt = cblen_r; left_nxt = left_r; rdir_nxt = rdir_r;
    res = '0;
    case (q_data.kind)
      sdh_pkg::K_READ: begin
        case (q_data.ofs)
          sdh_pkg::OFS_MR:      res.read_data = mode_r;
          sdh_pkg::OFS_DTOR:    res.read_data = dtor_r;
          sdh_pkg::OFS_SDCR:    res.read_data = sel_r;
          sdh_pkg::OFS_ARGR:    res.read_data = arg_r;
          sdh_pkg::OFS_BLKR:    res.read_data = blk_r;
          sdh_pkg::OFS_CSTOR:   res.read_data = cstor_r;
          sdh_pkg::OFS_RSPR0: begin
            res.read_data = rsp_r[rptr_r];
            rptr_nxt = rptr_r + 2'd1;
          end
          sdh_pkg::OFS_RSPR1:   res.read_data = rsp_r[1];
          sdh_pkg::OFS_RSPR2:   res.read_data = rsp_r[2];
          sdh_pkg::OFS_RSPR3:   res.read_data = rsp_r[3];
          sdh_pkg::OFS_SR:      res.read_data = sr_r;
          sdh_pkg::OFS_IMR:     res.read_data = imr_r;
          sdh_pkg::OFS_DMA:     res.read_data = dma_r;
          sdh_pkg::OFS_CFG:     res.read_data = cfg_r;
          sdh_pkg::OFS_WPMR:    res.read_data = wpmr_r;
          sdh_pkg::OFS_VERSION: res.read_data = sdh_pkg::VERSION_VALUE;
          default:              res.read_data = 32'd0;
        endcase
      end
      sdh_pkg::K_WRITE: begin
        case (q_data.ofs)
          sdh_pkg::OFS_CR: begin
            if (q_data.wdata[sdh_pkg::BIT_SWRST]) begin
              dtor_nxt = '0; arg_nxt = '0; blk_nxt = '0; cstor_nxt = '0;
              dma_nxt = '0; cfg_nxt = '0; wpmr_nxt = '0;
              sr_nxt = sdh_pkg::SR_RESET_VALUE; imr_nxt = '0;
              for (int i = 0; i < 4; i++) rsp_nxt[i] = '0;
              rptr_nxt = '0; cblen_nxt = '0; left_nxt = '0; rdir_nxt = 1'b0;
            end
          end
          sdh_pkg::OFS_MR:    mode_nxt = q_data.wdata;
          sdh_pkg::OFS_DTOR:  dtor_nxt = q_data.wdata;
          sdh_pkg::OFS_SDCR:  sel_nxt = q_data.wdata;
          sdh_pkg::OFS_ARGR:  arg_nxt = q_data.wdata;
          sdh_pkg::OFS_BLKR:  blk_nxt = q_data.wdata;
          sdh_pkg::OFS_CSTOR: cstor_nxt = q_data.wdata;
          sdh_pkg::OFS_IER:   imr_nxt = imr_r | q_data.wdata;
          sdh_pkg::OFS_IDR:   imr_nxt = imr_r & ~q_data.wdata;
          sdh_pkg::OFS_DMA:   dma_nxt = q_data.wdata;
          sdh_pkg::OFS_CFG:   cfg_nxt = q_data.wdata;
          sdh_pkg::OFS_WPMR:  wpmr_nxt = q_data.wdata;
          default: ;
        endcase
      end
      sdh_pkg::K_CMD: begin
        res.card_cmd_valid = 1'b1;
        res.card_cmd_index = q_data.wdata[5:0];
        res.card_cmd_arg   = arg_r;
        sr_nxt[sdh_pkg::BIT_RTOE] = (rtype != 2'd0) && (q_data.rlen == 5'd0);
        rptr_nxt = '0;
        if (rtype == 2'd2 && q_data.rlen == 5'd16) begin
          rsp_nxt[0] = q_data.hi[63:32];
          rsp_nxt[1] = q_data.hi[31:0];
          rsp_nxt[2] = q_data.lo[63:32];
          rsp_nxt[3] = q_data.lo[31:0];
        end else begin
          rsp_nxt[0] = (q_data.rlen >= 5'd4) ? q_data.hi[63:32] : 32'd0;
          rsp_nxt[1] = '0; rsp_nxt[2] = '0; rsp_nxt[3] = '0;
        end
        sr_nxt[sdh_pkg::BIT_CMDRDY] = 1'b1;
        if (q_data.wdata[17:16] == 2'd1) begin
          cblen_nxt = blen;
          left_nxt  = total[31] ? 32'd0 : total;
          rdir_nxt  = q_data.wdata[sdh_pkg::BIT_TRDIR];
          sr_nxt[sdh_pkg::BIT_NOTBUSY] = 1'b0;
          sr_nxt[sdh_pkg::BIT_BLKE]    = 1'b0;
          if (q_data.wdata[sdh_pkg::BIT_TRDIR]) sr_nxt[sdh_pkg::BIT_RXRDY] = 1'b1;
          else sr_nxt[sdh_pkg::BIT_TXRDY] = 1'b1;
        end
      end
      sdh_pkg::K_DATA: begin
        if (dir_ok) begin
          if (q_data.ofs == sdh_pkg::OFS_RDR) begin
            res.read_data       = q_data.cword;
            res.card_read_taken = 1'b1;
          end else begin
            res.card_write_valid = 1'b1;
            res.card_write_word  = q_data.wdata;
          end
          if (left_r <= 32'd4) begin
            sr_nxt[sdh_pkg::BIT_RXRDY]   = 1'b0;
            sr_nxt[sdh_pkg::BIT_TXRDY]   = 1'b1;
            sr_nxt[sdh_pkg::BIT_BLKE]    = 1'b1;
            sr_nxt[sdh_pkg::BIT_NOTBUSY] = 1'b1;
            left_nxt = '0;
          end else begin
            left_nxt = left_r - 32'd4;
          end
        end
      end
      default: ;
    endcase
    res.irq = |(sr_nxt & imr_nxt);
    res.data_req = (left_nxt != 32'd0) &&
                   (sr_nxt[sdh_pkg::BIT_RXRDY] || sr_nxt[sdh_pkg::BIT_TXRDY]);
  end

  always_comb begin
    ov_nxt  = go ? 1'b1 : (out_stall ? ov_r : 1'b0);
    out_nxt = go ? res : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      mode_r <= '0; dtor_r <= '0; sel_r <= '0; arg_r <= '0; blk_r <= '0;
      cstor_r <= '0; dma_r <= '0; cfg_r <= '0; wpmr_r <= '0;
      sr_r <= sdh_pkg::SR_RESET_VALUE; imr_r <= '0;
      for (int i = 0; i < 4; i++) rsp_r[i] <= '0;
      rptr_r <= '0; cblen_r <= '0; left_r <= '0; rdir_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (go) begin
        mode_r <= mode_nxt; dtor_r <= dtor_nxt; sel_r <= sel_nxt; arg_r <= arg_nxt;
        blk_r <= blk_nxt; cstor_r <= cstor_nxt; dma_r <= dma_nxt; cfg_r <= cfg_nxt;
        wpmr_r <= wpmr_nxt; sr_r <= sr_nxt; imr_r <= imr_nxt;
        for (int i = 0; i < 4; i++) rsp_r[i] <= rsp_nxt[i];
        rptr_r <= rptr_nxt; cblen_r <= cblen_nxt; left_r <= left_nxt; rdir_r <= rdir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  `SDH_ASSERT_IMPL(a_one_side, out_valid,
    !(out_data.card_read_taken && out_data.card_write_valid), "read and write same transfer")
  `SDH_ASSERT_IMPL(a_left_small, 1'b1, !left_r[31], "byte count out of range")
  `SDH_ASSERT_NEXT(a_hold, ov_r && out_stall, ov_r && $stable(out_r), "result dropped")
endmodule
`default_nettype wire

@@ rtl/sd_host_register_block.sv @@
// SD/MMC host register block, programmed I/O.
// Path: an accepted access is registered in the front queue stage, then in the output register.
// Throughput: one bus access per cycle while the receiver does not stall; the front queue holds two.
// Reset: synchronous rst_n; registers clear, status word loads 0xC0E5.
`default_nettype none
module sd_host_register_block (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sdh_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sdh_pkg::out_item_t       out_data
);
  logic         q_valid, q_stall;
  sdh_pkg::op_t q_data;

  sdh_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_stall, .q_data
  );

  sdh_back u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

@@ sim/tb_sd_host_register_block.sv @@
`default_nettype none
module tb_sd_host_register_block;

  localparam int unsigned NUM_RANDOM  = 1200;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 40;
  localparam logic [31:0] BLKE_MASK   = 32'h1 << sdh_pkg::BIT_BLKE;
  localparam logic [31:0] RX_MASK     = 32'h1 << sdh_pkg::BIT_RXRDY;
  localparam logic [31:0] TX_MASK     = 32'h1 << sdh_pkg::BIT_TXRDY;
  localparam logic [31:0] NB_MASK     = 32'h1 << sdh_pkg::BIT_NOTBUSY;
  localparam logic [31:0] CMDRDY_MASK = 32'h1 << sdh_pkg::BIT_CMDRDY;
  localparam logic [31:0] RTOE_MASK   = 32'h1 << sdh_pkg::BIT_RTOE;
  localparam logic [31:0] TRDIR_MASK  = 32'h1 << sdh_pkg::BIT_TRDIR;
  localparam logic [31:0] SWRST_MASK  = 32'h1 << sdh_pkg::BIT_SWRST;
  localparam logic [31:0] XFER_START  = 32'h0001_0000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sdh_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sdh_pkg::out_item_t out_data;

  sd_host_register_block dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // host register shadow
  logic [31:0] m_mode, m_dtor, m_sel, m_arg, m_blk, m_cstor, m_dma, m_cfg, m_wpmr;
  logic [31:0] m_status, m_mask, m_bytes;
  logic [31:0] m_resp [4];
  logic [1:0]  m_rptr;
  logic [15:0] m_cur_blen;
  logic        m_rd_dir;

  sdh_pkg::out_item_t expected_q [$];
  int unsigned n_fail, n_sent, n_seen, n_cmds, n_reads_taken, n_writes_sent;
  int unsigned idle_cycles;
  bit          no_idle, hold_rx, stim_done;

  function automatic void host_reset(input bit keep);
    logic [31:0] km, ks;
    km = m_mode; ks = m_sel;
    m_mode = 0; m_dtor = 0; m_sel = 0; m_arg = 0; m_blk = 0; m_cstor = 0;
    m_dma = 0; m_cfg = 0; m_wpmr = 0; m_status = sdh_pkg::SR_RESET_VALUE; m_mask = 0;
    for (int i = 0; i < 4; i++) m_resp[i] = 0;
    m_rptr = 0; m_cur_blen = 0; m_bytes = 0; m_rd_dir = 0;
    if (keep) begin
      m_mode = km; m_sel = ks;
    end
  endfunction

  function automatic void consume_word();
    if (m_bytes <= 4) begin
      m_status = (m_status & ~(RX_MASK | TX_MASK)) | TX_MASK | BLKE_MASK | NB_MASK;
      m_bytes = 0;
    end else begin
      m_bytes -= 4;
    end
  endfunction

  function automatic sdh_pkg::out_item_t host_access(input sdh_pkg::in_item_t it);
    sdh_pkg::out_item_t r;
    logic [4:0]  rlen;
    logic [31:0] v, blen, bcnt, total;
    logic [8:0]  w;
    logic [1:0]  rtype;
    r = '0;
    w = it.word_offset;
    v = it.write_data;
    rlen = (it.card_resp_len > 16) ? 5'd16 : it.card_resp_len;
    if (it.op == 1'b0) begin
      if (w >= 128 || w == sdh_pkg::OFS_RDR) begin
        if (m_bytes != 0 && m_rd_dir) begin
          r.card_read_taken = 1'b1;
          r.read_data = it.card_read_word;
          consume_word();
        end
      end else begin
        case (w)
          sdh_pkg::OFS_MR:      r.read_data = m_mode;
          sdh_pkg::OFS_DTOR:    r.read_data = m_dtor;
          sdh_pkg::OFS_SDCR:    r.read_data = m_sel;
          sdh_pkg::OFS_ARGR:    r.read_data = m_arg;
          sdh_pkg::OFS_BLKR:    r.read_data = m_blk;
          sdh_pkg::OFS_CSTOR:   r.read_data = m_cstor;
          sdh_pkg::OFS_RSPR0: begin
            r.read_data = m_resp[m_rptr];
            m_rptr = m_rptr + 2'd1;
          end
          sdh_pkg::OFS_RSPR1:   r.read_data = m_resp[1];
          sdh_pkg::OFS_RSPR2:   r.read_data = m_resp[2];
          sdh_pkg::OFS_RSPR3:   r.read_data = m_resp[3];
          sdh_pkg::OFS_SR:      r.read_data = m_status;
          sdh_pkg::OFS_IMR:     r.read_data = m_mask;
          sdh_pkg::OFS_DMA:     r.read_data = m_dma;
          sdh_pkg::OFS_CFG:     r.read_data = m_cfg;
          sdh_pkg::OFS_WPMR:    r.read_data = m_wpmr;
          sdh_pkg::OFS_VERSION: r.read_data = sdh_pkg::VERSION_VALUE;
          default:              r.read_data = '0;
        endcase
      end
    end else if (w >= 128 || w == sdh_pkg::OFS_TDR) begin
      if (m_bytes != 0 && !m_rd_dir) begin
        r.card_write_valid = 1'b1;
        r.card_write_word = v;
        consume_word();
      end
    end else begin
      case (w)
        sdh_pkg::OFS_CR:    if ((v & SWRST_MASK) != 0) host_reset(1'b1);
        sdh_pkg::OFS_MR:    m_mode = v;
        sdh_pkg::OFS_DTOR:  m_dtor = v;
        sdh_pkg::OFS_SDCR:  m_sel = v;
        sdh_pkg::OFS_ARGR:  m_arg = v;
        sdh_pkg::OFS_BLKR:  m_blk = v;
        sdh_pkg::OFS_CSTOR: m_cstor = v;
        sdh_pkg::OFS_IER:   m_mask |= v;
        sdh_pkg::OFS_IDR:   m_mask &= ~v;
        sdh_pkg::OFS_DMA:   m_dma = v;
        sdh_pkg::OFS_CFG:   m_cfg = v;
        sdh_pkg::OFS_WPMR:  m_wpmr = v;
        sdh_pkg::OFS_CMDR: begin
          rtype = v[7:6];
          r.card_cmd_valid = 1'b1;
          r.card_cmd_index = v[5:0];
          r.card_cmd_arg = m_arg;
          m_status &= ~RTOE_MASK;
          if (rtype != 0 && rlen == 0) m_status |= RTOE_MASK;
          m_rptr = 0;
          if (rtype == 2 && rlen == 16) begin
            m_resp[0] = it.card_resp_high[63:32];
            m_resp[1] = it.card_resp_high[31:0];
            m_resp[2] = it.card_resp_low[63:32];
            m_resp[3] = it.card_resp_low[31:0];
          end else begin
            m_resp[0] = (rlen >= 4) ? it.card_resp_high[63:32] : '0;
            m_resp[1] = 0; m_resp[2] = 0; m_resp[3] = 0;
          end
          m_status |= CMDRDY_MASK;
          if (v[17:16] == 2'd1) begin
            blen = {16'h0, m_blk[31:16]};
            bcnt = {16'h0, m_blk[15:0]};
            if (blen == 0) blen = {16'h0, m_mode[31:16]};
            if (bcnt == 0) bcnt = 1;
            m_cur_blen = blen[15:0];
            total = blen * bcnt;
            m_bytes = total[31] ? '0 : total;
            m_rd_dir = (v & TRDIR_MASK) != 0;
            m_status &= ~(NB_MASK | BLKE_MASK);
            m_status |= m_rd_dir ? RX_MASK : TX_MASK;
          end
        end
        default: ;
      endcase
    end
    r.irq = (m_status & m_mask) != 0;
    r.data_req = (m_bytes != 0) && ((m_status & (RX_MASK | TX_MASK)) != 0);
    return r;
  endfunction

  // drive one access, hold until accepted; a fixed row types in the read value
  task automatic bus_access_rd(input sdh_pkg::in_item_t it, input bit fixed,
                               input logic [31:0] rd);
    int unsigned gap;
    sdh_pkg::out_item_t r;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = host_access(it);
    if (fixed) r.read_data = rd;
    expected_q.push_back(r);
    n_sent++;
  endtask

  task automatic bus_access(input sdh_pkg::in_item_t it);
    bus_access_rd(it, 1'b0, 32'h0);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic sdh_pkg::in_item_t mk(input logic op, input logic [8:0] w,
                                           input logic [31:0] d);
    sdh_pkg::in_item_t it;
    it.op = op;
    it.word_offset = w;
    it.write_data = d;
    it.card_resp_len = 5'($urandom_range(0, 31));
    it.card_resp_high = {$urandom, $urandom};
    it.card_resp_low = {$urandom, $urandom};
    it.card_read_word = $urandom;
    return it;
  endfunction

  // receiver
  always @(posedge clk) begin
    sdh_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (out_data.card_cmd_valid) n_cmds++;
      if (out_data.card_read_taken) n_reads_taken++;
      if (out_data.card_write_valid) n_writes_sent++;
      if (expected_q.size() == 0) begin
        $error("result with none expected");
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.read_data !== e.read_data) begin
          $error("read_data exp %h got %h", e.read_data, out_data.read_data); n_fail++;
        end
        if (out_data.irq !== e.irq) begin
          $error("irq exp %b got %b", e.irq, out_data.irq); n_fail++;
        end
        if (out_data.data_req !== e.data_req) begin
          $error("data_req exp %b got %b", e.data_req, out_data.data_req);
          n_fail++;
        end
        if (out_data.card_cmd_valid !== e.card_cmd_valid) begin
          $error("card_cmd_valid exp %b got %b", e.card_cmd_valid,
                 out_data.card_cmd_valid); n_fail++;
        end
        if (out_data.card_cmd_index !== e.card_cmd_index) begin
          $error("card_cmd_index exp %h got %h", e.card_cmd_index,
                 out_data.card_cmd_index); n_fail++;
        end
        if (out_data.card_cmd_arg !== e.card_cmd_arg) begin
          $error("card_cmd_arg exp %h got %h", e.card_cmd_arg, out_data.card_cmd_arg);
          n_fail++;
        end
        if (out_data.card_read_taken !== e.card_read_taken) begin
          $error("card_read_taken exp %b got %b", e.card_read_taken,
                 out_data.card_read_taken); n_fail++;
        end
        if (out_data.card_write_valid !== e.card_write_valid) begin
          $error("card_write_valid exp %b got %b", e.card_write_valid,
                 out_data.card_write_valid); n_fail++;
        end
        if (out_data.card_write_word !== e.card_write_word) begin
          $error("card_write_word exp %h got %h", e.card_write_word,
                 out_data.card_write_word); n_fail++;
        end
      end
    end
  end

  // receiver stall: random bursts, one long hold-off on request
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_rx = 1'b0;
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (stim_done && expected_q.size() == 0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  typedef struct {
    logic        op;
    logic [8:0]  ofs;
    logic [31:0] data;
    logic [4:0]  rlen;
    bit          fixed;
    logic [31:0] rd;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{1'b0, sdh_pkg::OFS_SR,      32'h0,         5'd0,  1'b1, sdh_pkg::SR_RESET_VALUE},
    '{1'b0, sdh_pkg::OFS_VERSION, 32'h0,         5'd0,  1'b1, sdh_pkg::VERSION_VALUE},
    '{1'b0, sdh_pkg::OFS_WPSR,    32'h0,         5'd0,  1'b1, 32'h0},
    '{1'b0, sdh_pkg::OFS_CR,      32'h0,         5'd0,  1'b1, 32'h0},
    '{1'b0, sdh_pkg::OFS_RDR,     32'h0,         5'd0,  1'b1, 32'h0},
    '{1'b1, sdh_pkg::OFS_MR,      32'hFFFF_FFFF, 5'd0,  1'b0, 32'h0},
    '{1'b0, sdh_pkg::OFS_MR,      32'h0,         5'd0,  1'b1, 32'hFFFF_FFFF},
    '{1'b1, sdh_pkg::OFS_ARGR,    32'h1234_5678, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_IER,     32'hFFFF_FFFF, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CMDR,    32'h0000_00BF, 5'd16, 1'b0, 32'h0},
    '{1'b0, sdh_pkg::OFS_RSPR0,   32'h0,         5'd0,  1'b0, 32'h0},
    '{1'b0, sdh_pkg::OFS_RSPR0,   32'h0,         5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CMDR,    32'h0000_0041, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CMDR,    32'h0000_0082, 5'd31, 1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CMDR,    32'h0000_0042, 5'd7,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_BLKR,    32'h0000_0003, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CMDR,    32'h0001_0000, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_BLKR,    32'h0006_0001, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CMDR,    32'h0005_0011, 5'd0,  1'b0, 32'h0},
    '{1'b0, 9'd383,               32'h0,         5'd0,  1'b0, 32'h0},
    '{1'b0, 9'd128,               32'h0,         5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_TDR,     32'hFFFF_FFFF, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_IDR,     32'hFFFF_FFFF, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CR,      32'hFFFF_FF7F, 5'd0,  1'b0, 32'h0},
    '{1'b1, sdh_pkg::OFS_CR,      SWRST_MASK,    5'd0,  1'b0, 32'h0}
  };

  sdh_pkg::in_item_t it;
  int unsigned blen, bcnt, words;
  logic [31:0] cmd;

  initial begin
    host_reset(1'b0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it = mk(dir_rows[i].op, dir_rows[i].ofs, dir_rows[i].data);
      it.card_resp_len = dir_rows[i].rlen;
      bus_access_rd(it, dir_rows[i].fixed, dir_rows[i].rd);
    end
    go_idle();

    // long receiver hold-off while sender keeps offering
    hold_rx = 1'b1;
    for (int i = 0; i < 30; i++) bus_access(mk(1'b0, sdh_pkg::OFS_SR, 32'h0));
    go_idle();

    while (n_sent < NUM_RANDOM + 60) begin
      if (n_sent > NUM_RANDOM - 150) no_idle = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        // well-formed transfer: block setup, command, data words, status checks
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 24);
        bcnt = $urandom_range(0, 3);
        if ($urandom_range(0, 30) == 0) begin
          blen = 16'hFFFF; bcnt = 16'hFFFF;
        end
        if (blen == 0) bus_access(mk(1'b1, sdh_pkg::OFS_MR,
                                     {$urandom_range(0, 12)} << 16 |
                                     $urandom_range(0, 65535)));
        bus_access(mk(1'b1, sdh_pkg::OFS_BLKR, {blen[15:0], bcnt[15:0]}));
        bus_access(mk(1'b1, sdh_pkg::OFS_ARGR, $urandom));
        cmd = $urandom & ~32'h0003_0000;
        cmd |= XFER_START;
        bus_access(mk(1'b1, sdh_pkg::OFS_CMDR, cmd));
        words = $urandom_range(0, 14);
        for (int k = 0; k < words; k++) begin
          case ($urandom_range(0, 5))
            0: bus_access(mk(1'b0, sdh_pkg::OFS_RDR, 32'h0));
            1: bus_access(mk(1'b1, sdh_pkg::OFS_TDR, $urandom));
            2: bus_access(mk(1'b0, 9'($urandom_range(128, 511)), 32'h0));
            3: bus_access(mk(1'b1, 9'($urandom_range(128, 511)), $urandom));
            4: bus_access(mk(1'b0, cmd[sdh_pkg::BIT_TRDIR] ? sdh_pkg::OFS_RDR :
                             sdh_pkg::OFS_TDR, $urandom));
            default: bus_access(mk(1'b0, sdh_pkg::OFS_SR, 32'h0));
          endcase
        end
      end else begin
        case ($urandom_range(0, 5))
          0: bus_access(mk(1'b0, 9'($urandom_range(0, 63)), 32'h0));
          1: bus_access(mk(1'b1, 9'($urandom_range(0, 63)), $urandom));
          2: bus_access(mk(1'b1, sdh_pkg::OFS_CMDR, $urandom & ~32'h0001_0000));
          3: bus_access(mk(1'b0, 9'($urandom_range(8, 11)), 32'h0));
          4: bus_access(mk(1'b1, $urandom_range(0, 1) ? sdh_pkg::OFS_IER : sdh_pkg::OFS_IDR,
                           $urandom));
          default: bus_access(mk(1'($urandom_range(0, 1)), 9'($urandom), $urandom));
        endcase
      end
      if (n_sent > 400 && n_sent < 420) go_idle();  // sender pause to drain
    end

    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d accesses, %0d results, %0d commands issued,", n_sent, n_seen,
             n_cmds);
    $display("%0d card reads taken and %0d card writes sent.", n_reads_taken,
             n_writes_sent);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
